// File: rtl/mtd_pkg.sv
// Shared types, constants and the Morse tree lookup for the Morse key timing decoder.
// No dependencies; every other rtl file refers to this package by scoped names.
package mtd_pkg;

    localparam int TIME_BITS      = 32;
    localparam int CFG_BITS       = 16;
    localparam int MAX_SYMBOLS    = 4;
    localparam int COUNT_BITS     = 3;
    localparam int SYM_IDX_BITS   = $clog2(MAX_SYMBOLS);
    localparam int POS_BITS       = 5;
    localparam int TREE_SIZE      = 28;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam int PADDR_BITS     = 4;
    localparam int PDATA_BITS     = 32;
    localparam int REG_IDX_BITS   = 2;

    localparam logic [REG_IDX_BITS-1:0] REG_DASH_THRESHOLD = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_LETTER_GAP     = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_WORD_GAP       = 2'd2;

    localparam logic [CFG_BITS-1:0] DASH_THRESHOLD_RST = 16'd200;
    localparam logic [CFG_BITS-1:0] LETTER_GAP_RST     = 16'd200;
    localparam logic [CFG_BITS-1:0] WORD_GAP_RST       = 16'd600;

    localparam logic [6:0] CHAR_SPACE = 7'd32;
    localparam logic [6:0] CHAR_BAD   = 7'd42;

    typedef struct packed {
        logic        key_level;
        logic [31:0] time_ms;
    } in_item_t;

    typedef struct packed {
        logic [6:0] character;
        logic       bad_code;
        logic       is_last;
    } out_item_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] dash_threshold_ms;
        logic [CFG_BITS-1:0] letter_gap_ms;
        logic [CFG_BITS-1:0] word_gap_ms;
    } cfg_t;

    // results of one edge: optional letter, optional word space after it
    typedef struct packed {
        logic       has_letter;
        logic [6:0] letter;
        logic       bad;
        logic       has_space;
    } edge_rec_t;

    // preorder tree position: start at -1, a dot steps one, a dash skips the dot subtree
    function automatic logic [POS_BITS-1:0] code_pos(input logic [COUNT_BITS-1:0] count,
                                                     input logic [MAX_SYMBOLS-1:0] pattern);
        logic [POS_BITS-1:0] pos;
        pos = '1;
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (COUNT_BITS'(i) < count) begin
                if (pattern[i]) begin
                    pos = pos + (POS_BITS'(1) << (MAX_SYMBOLS - i));
                end else begin
                    pos = pos + POS_BITS'(1);
                end
            end
        end
        return pos;
    endfunction

    function automatic logic [6:0] tree_letter(input logic [POS_BITS-1:0] pos);
        logic [6:0] ch;
        unique case (pos)
            5'd0:  ch = 7'd69;  // E
            5'd1:  ch = 7'd73;  // I
            5'd2:  ch = 7'd83;  // S
            5'd3:  ch = 7'd72;  // H
            5'd4:  ch = 7'd86;  // V
            5'd5:  ch = 7'd85;  // U
            5'd6:  ch = 7'd70;  // F
            5'd8:  ch = 7'd65;  // A
            5'd9:  ch = 7'd82;  // R
            5'd10: ch = 7'd76;  // L
            5'd12: ch = 7'd87;  // W
            5'd13: ch = 7'd80;  // P
            5'd14: ch = 7'd74;  // J
            5'd15: ch = 7'd84;  // T
            5'd16: ch = 7'd78;  // N
            5'd17: ch = 7'd68;  // D
            5'd18: ch = 7'd66;  // B
            5'd19: ch = 7'd88;  // X
            5'd20: ch = 7'd75;  // K
            5'd21: ch = 7'd67;  // C
            5'd22: ch = 7'd89;  // Y
            5'd23: ch = 7'd77;  // M
            5'd24: ch = 7'd71;  // G
            5'd25: ch = 7'd90;  // Z
            5'd26: ch = 7'd81;  // Q
            5'd27: ch = 7'd79;  // O
            default: ch = CHAR_BAD;  // unassigned slots and past the end of the tree
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/mtd_front.sv
// Front end: accepts key edges, measures press and gap lengths, builds the letter.
// Pushes one edge record per edge that yields results. Uses mtd_pkg.
module mtd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  mtd_pkg::cfg_t       cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  mtd_pkg::in_item_t   s_data,
    input  logic                q_full,
    output logic                q_push,
    output mtd_pkg::edge_rec_t  q_data
);

    logic [mtd_pkg::TIME_BITS-1:0]   last_time_reg, last_time_next;
    logic                            edge_seen_reg, edge_seen_next;
    logic [mtd_pkg::COUNT_BITS-1:0]  count_reg, count_next;
    logic [mtd_pkg::MAX_SYMBOLS-1:0] pattern_reg, pattern_next;
    logic                            too_long_reg, too_long_next;

    logic                            accept;
    logic [mtd_pkg::TIME_BITS-1:0]   now;
    logic [mtd_pkg::TIME_BITS-1:0]   elapsed;
    logic                            letter_hit;
    logic                            word_hit;
    logic                            dash_hit;
    logic [mtd_pkg::POS_BITS-1:0]    pos;
    logic [6:0]                      tree_char;
    logic                            letter_bad;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign now        = s_data.time_ms[mtd_pkg::TIME_BITS-1:0];
    assign elapsed    = now - last_time_reg;
    assign letter_hit = elapsed > mtd_pkg::TIME_BITS'(cfg.letter_gap_ms);
    assign word_hit   = elapsed > mtd_pkg::TIME_BITS'(cfg.word_gap_ms);
    assign dash_hit   = elapsed > mtd_pkg::TIME_BITS'(cfg.dash_threshold_ms);
    assign pos        = mtd_pkg::code_pos(count_reg, pattern_reg);
    assign tree_char  = mtd_pkg::tree_letter(pos);
    assign letter_bad = too_long_reg || (tree_char == mtd_pkg::CHAR_BAD);

    always_comb begin
        last_time_next = last_time_reg;
        edge_seen_next = edge_seen_reg;
        count_next     = count_reg;
        pattern_next   = pattern_reg;
        too_long_next  = too_long_reg;
        q_push         = 1'b0;
        q_data         = '0;
        q_data.letter  = letter_bad ? mtd_pkg::CHAR_BAD : tree_char;
        q_data.bad     = letter_bad;

        if (accept) begin
            edge_seen_next = 1'b1;
            last_time_next = now;
            if (edge_seen_reg) begin
                if (!s_data.key_level) begin
                    q_data.has_letter = letter_hit && (count_reg != '0);
                    q_data.has_space  = word_hit;
                    q_push            = q_data.has_letter || word_hit;
                    // a word gap drops the letter too, emitted or not
                    if (letter_hit || word_hit) begin
                        count_next    = '0;
                        pattern_next  = '0;
                        too_long_next = 1'b0;
                    end
                end else if (count_reg < mtd_pkg::COUNT_BITS'(mtd_pkg::MAX_SYMBOLS)) begin
                    if (dash_hit) begin
                        pattern_next[count_reg[mtd_pkg::SYM_IDX_BITS-1:0]] = 1'b1;
                    end
                    count_next = count_reg + mtd_pkg::COUNT_BITS'(1);
                end else begin
                    too_long_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg <= '0;
            edge_seen_reg <= 1'b0;
            count_reg     <= '0;
            pattern_reg   <= '0;
            too_long_reg  <= 1'b0;
        end else begin
            last_time_reg <= last_time_next;
            edge_seen_reg <= edge_seen_next;
            count_reg     <= count_next;
            pattern_reg   <= pattern_next;
            too_long_reg  <= too_long_next;
        end
    end

    a_push_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_data.has_letter || q_data.has_space))
        else $error("edge record pushed with no result");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= mtd_pkg::COUNT_BITS'(mtd_pkg::MAX_SYMBOLS))
        else $error("symbol count beyond letter length");

    a_too_long_full: assert property (@(posedge aclk) disable iff (!aresetn)
        too_long_reg |-> (count_reg == mtd_pkg::COUNT_BITS'(mtd_pkg::MAX_SYMBOLS)))
        else $error("overlong flag set on a short letter");

endmodule

// File: rtl/mtd_queue.sv
// Short FIFO of edge records between the front end and the output stage.
// Flip-flop storage, one push (while not full) and one pop (while not empty) per cycle. Uses mtd_pkg.
module mtd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  mtd_pkg::edge_rec_t  push_data,
    input  logic                pop,
    output mtd_pkg::edge_rec_t  pop_data,
    output logic                full,
    output logic                empty
);

    mtd_pkg::edge_rec_t                 store_reg [mtd_pkg::QUEUE_DEPTH];
    logic [mtd_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mtd_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mtd_pkg::QUEUE_CNT_BITS-1:0] count_reg, count_next;

    assign full     = count_reg == mtd_pkg::QUEUE_CNT_BITS'(mtd_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + mtd_pkg::QUEUE_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + mtd_pkg::QUEUE_PTR_BITS'(1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + mtd_pkg::QUEUE_CNT_BITS'(1);
            2'b01:   count_next = count_reg - mtd_pkg::QUEUE_CNT_BITS'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg == rd_ptr_reg) |-> (empty || full))
        else $error("queue pointers disagree with fill count");

endmodule

// File: rtl/mtd_back.sv
// Output stage: pops edge records and sends their letter and space results one at a time.
// Registered output; m_ready feeds the queue pop directly. Uses mtd_pkg.
module mtd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  mtd_pkg::edge_rec_t  q_data,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output mtd_pkg::out_item_t  m_data
);

    logic               m_valid_reg, m_valid_next;
    mtd_pkg::out_item_t m_data_reg, m_data_next;
    logic               space_pend_reg, space_pend_next;
    logic               load;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign load    = !m_valid_reg || m_ready;
    assign q_pop   = load && !space_pend_reg && !q_empty;

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        space_pend_next = space_pend_reg;
        if (load) begin
            if (space_pend_reg) begin
                m_valid_next          = 1'b1;
                m_data_next.character = mtd_pkg::CHAR_SPACE;
                m_data_next.bad_code  = 1'b0;
                m_data_next.is_last   = 1'b1;
                space_pend_next       = 1'b0;
            end else if (!q_empty) begin
                m_valid_next = 1'b1;
                if (q_data.has_letter) begin
                    m_data_next.character = q_data.letter;
                    m_data_next.bad_code  = q_data.bad;
                    m_data_next.is_last   = !q_data.has_space;
                    space_pend_next       = q_data.has_space;
                end else begin
                    m_data_next.character = mtd_pkg::CHAR_SPACE;
                    m_data_next.bad_code  = 1'b0;
                    m_data_next.is_last   = 1'b1;
                end
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            space_pend_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            space_pend_reg <= space_pend_next;
        end
    end

    a_pend_behind_letter: assert property (@(posedge aclk) disable iff (!aresetn)
        space_pend_reg |-> (m_valid_reg && !m_data_reg.is_last))
        else $error("pending space without a letter in front of it");

    a_no_pop_while_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (space_pend_reg && !m_ready) |=> space_pend_reg)
        else $error("pending space lost while stalled");

endmodule

// File: rtl/morse_timing_decoder_core.sv
// Morse key timing decoder, top level: APB register file, front end, queue, output stage.
// Depends on mtd_pkg, mtd_front, mtd_queue and mtd_back.
//
// Usage:
//  - s_valid/s_ready/s_data carry key edges (new key level, millisecond timestamp).
//    A transaction takes place when valid and ready are both high at a rising edge.
//  - m_valid/m_ready/m_data carry decoded characters: a letter, '*' with bad_code
//    for a bad or overlong code, and a space for a word gap; is_last marks the final
//    result of an edge. An edge gives zero, one or two results.
//  - APB registers: 0x0 dash threshold, 0x4 letter gap, 0x8 word gap (16 bits, ms).
//    Write only while the decoder is idle.
//  - Result path: the front end writes the queue at the accepting edge, and the
//    output register loads from the queue once it is free; a second result from
//    the same edge follows once the first has been taken.
//  - Throughput: one edge per cycle while the queue is not full; the output register
//    emits one result per cycle while m_ready is high, two-result edges included.
//  - Receiver stall: results collect in a four-entry edge queue; s_ready drops only
//    when that queue is full.
//  - Reset (aresetn low, synchronous): registers take 200/200/600 ms, the letter is
//    cleared and the next edge only sets the time reference.
module morse_timing_decoder_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mtd_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [mtd_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [mtd_pkg::PDATA_BITS-1:0]     prdata,
    output logic                               pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  mtd_pkg::in_item_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output mtd_pkg::out_item_t                 m_data
);

    mtd_pkg::cfg_t                     cfg_reg, cfg_next;
    logic                              cfg_write;
    logic [mtd_pkg::REG_IDX_BITS-1:0]  reg_idx;
    logic                              q_full;
    logic                              q_empty;
    logic                              q_push;
    logic                              q_pop;
    mtd_pkg::edge_rec_t                q_wr_data;
    mtd_pkg::edge_rec_t                q_rd_data;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[mtd_pkg::PADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (reg_idx)
                mtd_pkg::REG_DASH_THRESHOLD:
                    cfg_next.dash_threshold_ms = pwdata[mtd_pkg::CFG_BITS-1:0];
                mtd_pkg::REG_LETTER_GAP:
                    cfg_next.letter_gap_ms = pwdata[mtd_pkg::CFG_BITS-1:0];
                mtd_pkg::REG_WORD_GAP:
                    cfg_next.word_gap_ms = pwdata[mtd_pkg::CFG_BITS-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            mtd_pkg::REG_DASH_THRESHOLD:
                prdata = mtd_pkg::PDATA_BITS'(cfg_reg.dash_threshold_ms);
            mtd_pkg::REG_LETTER_GAP:
                prdata = mtd_pkg::PDATA_BITS'(cfg_reg.letter_gap_ms);
            mtd_pkg::REG_WORD_GAP:
                prdata = mtd_pkg::PDATA_BITS'(cfg_reg.word_gap_ms);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dash_threshold_ms <= mtd_pkg::DASH_THRESHOLD_RST;
            cfg_reg.letter_gap_ms     <= mtd_pkg::LETTER_GAP_RST;
            cfg_reg.word_gap_ms       <= mtd_pkg::WORD_GAP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mtd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_wr_data)
    );

    mtd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wr_data),
        .pop       (q_pop),
        .pop_data  (q_rd_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    mtd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (q_rd_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
